[hdl/lsm_pkg.sv]
// Shared definitions for the line substring matcher: widths, byte codes,
// register indexes, the match configuration struct and the case fold.
// No dependencies.
package lsm_pkg;

  // Defaults for the top-level parameters.
  localparam int PATTERN_BYTES_DEFAULT = 16;
  localparam int CHUNK_LIMIT_DEFAULT   = 100;

  // Number of pattern bytes the two pattern registers can hold.
  localparam int REG_PATTERN_BYTES = 16;

  // Field and port widths.
  localparam int LEN_W       = 5;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;
  localparam int LINE_W      = 32;
  localparam int CHUNK_LEN_W = 7;

  typedef logic [7:0] byte_t;

  // Byte codes.
  localparam byte_t NUL_BYTE     = 8'h00;
  localparam byte_t NEWLINE_BYTE = 8'h0A;
  localparam byte_t UPPER_A      = 8'h41;
  localparam byte_t UPPER_Z      = 8'h5A;
  localparam byte_t CASE_OFFSET  = 8'h20;

  // Configuration register indexes (byte address is eight times the index).
  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_FOLD_CASE      = 2'd3
  } reg_index_t;

  // Settings that the datapath takes from the register block.
  typedef struct packed {
    logic [LEN_W-1:0] eff_len;
    logic             fold_case;
  } match_cfg_t;

  // Folds ASCII uppercase to lowercase when case is ignored.
  function automatic byte_t fold_byte(byte_t b, logic fold_en);
    if (fold_en && b >= UPPER_A && b <= UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

endpackage

[hdl/lsm_cfg.sv]
// Configuration registers of the line substring matcher, with the APB
// write and read paths and the per-cell view of the pattern.
// Depends on lsm_pkg.
module lsm_cfg #(
  parameter int CELLS = lsm_pkg::PATTERN_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lsm_pkg::ADDR_W-1:0]         paddr,
  input  logic [lsm_pkg::DATA_W-1:0]         pwdata,
  output logic [lsm_pkg::DATA_W-1:0]         prdata,
  output lsm_pkg::match_cfg_t                cfg,
  output lsm_pkg::byte_t [CELLS-1:0]         cell_pattern,
  output logic [CELLS-1:0]                   cell_active
);
  import lsm_pkg::*;

  localparam int PAT_W = 8 * REG_PATTERN_BYTES;

  logic [DATA_W-1:0] pattern_low;
  logic [DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]  pattern_length;
  logic              fold_case;

  logic              write_en;
  reg_index_t        reg_index;
  logic [PAT_W-1:0]  pat_word;
  logic [PAT_W-1:0]  rev_word;
  logic [PAT_W-1:0]  aligned_word;
  logic [LEN_W-1:0]  clip_len;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  shift_bytes;

  assign write_en  = psel && penable && pwrite;
  assign reg_index = reg_index_t'(paddr[ADDR_W-1:3]);

  // Register writes; the registers hold only their defined bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      fold_case      <= 1'b0;
    end else if (write_en) begin
      unique case (reg_index)
        REG_PATTERN_LOW:    pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LEN_W-1:0];
        REG_FOLD_CASE:      fold_case      <= pwdata[0];
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    unique case (reg_index)
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_PATTERN_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, pattern_length};
      REG_FOLD_CASE:      prdata = {{(DATA_W-1){1'b0}}, fold_case};
    endcase
  end

  assign pat_word = {pattern_high, pattern_low};

  // Length in effect: clipped to the cell count and cut at the first NUL.
  always_comb begin
    if (pattern_length > LEN_W'(CELLS)) begin
      clip_len = LEN_W'(CELLS);
    end else begin
      clip_len = pattern_length;
    end
    eff_len = clip_len;
    for (int i = CELLS - 1; i >= 0; i--) begin
      if (LEN_W'(i) < clip_len && pat_word[8*i +: 8] == NUL_BYTE) begin
        eff_len = LEN_W'(i);
      end
    end
  end

  // Reverse the byte order so that one right shift lines up the last
  // pattern byte with the newest cell.
  always_comb begin
    for (int j = 0; j < REG_PATTERN_BYTES; j++) begin
      rev_word[8*j +: 8] = pat_word[8*(REG_PATTERN_BYTES-1-j) +: 8];
    end
  end

  assign shift_bytes  = LEN_W'(REG_PATTERN_BYTES) - eff_len;
  assign aligned_word = rev_word >> {shift_bytes, 3'b000};

  // Cell k compares against pattern byte eff_len-1-k, folded as the text is.
  always_comb begin
    for (int k = 0; k < CELLS; k++) begin
      cell_pattern[k] = fold_byte(aligned_word[8*k +: 8], fold_case);
      cell_active[k]  = LEN_W'(k) < eff_len;
    end
  end

  assign cfg.eff_len   = eff_len;
  assign cfg.fold_case = fold_case;

endmodule

[hdl/lsm_cell.sv]
// One cell of the text window: holds one recent byte, passes it on to the
// next cell on every shift and compares the arriving byte with its pattern byte.
// Depends on lsm_pkg.
module lsm_cell (
  input  logic           clk,
  input  logic           shift,
  input  lsm_pkg::byte_t byte_in,
  input  lsm_pkg::byte_t pattern,
  input  logic           active,
  output lsm_pkg::byte_t stored,
  output logic           hit
);
  import lsm_pkg::*;

  // Window byte; it moves one cell along with each searched byte.
  always_ff @(posedge clk) begin
    if (shift) begin
      stored <= byte_in;
    end
  end

  // The arriving byte is the one this cell holds after the shift.
  assign hit = !active || (byte_in == pattern);

endmodule

[hdl/line_substring_matcher_unit.sv]
// Line substring matcher: top level with chunking, line counting, the cell
// chain and the result register.
// Depends on lsm_pkg, lsm_cfg and lsm_cell.
//
// Text arrives one byte per transfer on the input channel (text_byte, with
// final_byte marking the last byte of the input). A chunk ends at a newline,
// after CHUNK_LIMIT-1 bytes or at the final byte; for each chunk one result
// transfer carries matched, line_number and chunk_length.
// Each byte is handled in the cycle it is taken; while the output register is
// free or being taken a new byte can be taken on every clock, one byte per cycle.
// A result enters the output register in the cycle after its chunk's last byte.
// The window is a chain of one cell per pattern byte; each cell compares the
// byte arriving in it, so the match decision is one AND over the chain.
// While a result waits to be taken the input stays ready as long as the
// receiver takes it in the same cycle; a stalled receiver stops input until
// the result is taken. The pattern registers are written and read over the
// APB port, pready is always high.
// Reset clears the chunk state, the line counter, the result valid flag and
// all configuration registers; no clearing pass is needed.
module line_substring_matcher_unit #(
  parameter int PATTERN_BYTES = lsm_pkg::PATTERN_BYTES_DEFAULT,
  parameter int CHUNK_LIMIT   = lsm_pkg::CHUNK_LIMIT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lsm_pkg::byte_t                  text_byte,
  input  logic                            final_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            matched,
  output logic [lsm_pkg::LINE_W-1:0]      line_number,
  output logic [lsm_pkg::CHUNK_LEN_W-1:0] chunk_length,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsm_pkg::ADDR_W-1:0]      paddr,
  input  logic [lsm_pkg::DATA_W-1:0]      pwdata,
  output logic [lsm_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import lsm_pkg::*;

  // Pattern bytes beyond the registers read as NUL, so no more cells are used.
  localparam int CELLS = (PATTERN_BYTES < REG_PATTERN_BYTES) ?
                         PATTERN_BYTES : REG_PATTERN_BYTES;
  localparam int CNT_W = $clog2(CHUNK_LIMIT);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  match_cfg_t         cfg;
  byte_t [CELLS-1:0]  cell_pattern;
  logic  [CELLS-1:0]  cell_active;
  byte_t              chain [CELLS];
  logic  [CELLS-1:0]  hits;

  logic               in_xfer;
  logic               out_xfer;
  byte_t              folded;
  logic               shift;
  logic               match_now;
  logic               ends;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               after_nul;
  logic               found;
  logic [LINE_W-1:0]  chunk_counter;
  logic [LINE_W-1:0]  chunk_counter_next;

  assign pready = 1'b1;

  lsm_cfg #(
    .CELLS (CELLS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .cfg          (cfg),
    .cell_pattern (cell_pattern),
    .cell_active  (cell_active)
  );

  // Handshake: the output register frees up in the cycle it is taken.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Bytes after a NUL in the chunk, and the NUL itself, are not searched.
  assign folded = fold_byte(text_byte, cfg.fold_case);
  assign shift  = in_xfer && !after_nul && (text_byte != NUL_BYTE);

  // Chain of window cells; cell 0 takes the newest byte.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    byte_t cell_in;
    if (k == 0) begin : g_head
      assign cell_in = folded;
    end else begin : g_link
      assign cell_in = chain[k-1];
    end
    lsm_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .byte_in (cell_in),
      .pattern (cell_pattern[k]),
      .active  (cell_active[k]),
      .stored  (chain[k]),
      .hit     (hits[k])
    );
  end

  // Chunk length so far, including this byte; it never reaches 2**CNT_W.
  assign count_next = count + 1'b1;

  // A hit needs the whole pattern to lie inside the current chunk.
  assign match_now = shift && (cfg.eff_len != '0) &&
                     (CMP_W'(count_next) >= CMP_W'(cfg.eff_len)) && (&hits);

  assign ends = (text_byte == NEWLINE_BYTE) ||
                (count_next >= CNT_W'(CHUNK_LIMIT - 1)) || final_byte;

  // Line counter saturates at its maximum.
  assign chunk_counter_next = (chunk_counter == '1) ? chunk_counter :
                              chunk_counter + 1'b1;

  // Chunk state, line counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      after_nul     <= 1'b0;
      found         <= 1'b0;
      chunk_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A new result refills the register in the cycle the old one leaves.
      priority if (in_xfer && ends) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
      if (in_xfer) begin
        if (ends) begin
          count         <= '0;
          after_nul     <= 1'b0;
          found         <= 1'b0;
          chunk_counter <= chunk_counter_next;
        end else begin
          count <= count_next;
          if (text_byte == NUL_BYTE) begin
            after_nul <= 1'b1;
          end
          if (match_now) begin
            found <= 1'b1;
          end
        end
      end
    end
  end

  // Result payload, loaded by the byte that ends a chunk.
  always_ff @(posedge clk) begin
    if (in_xfer && ends) begin
      matched      <= found || match_now || (cfg.eff_len == '0);
      line_number  <= chunk_counter_next;
      chunk_length <= CHUNK_LEN_W'(count_next);
    end
  end

  // The stored chunk length stays below the point at which a chunk is cut.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CHUNK_LIMIT - 2))
    else $error("chunk byte count past the chunk limit");

  // A chunk that ends leaves a result and a cleared chunk state behind.
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && ends) |=> (out_valid && count == '0 && !found && !after_nul))
    else $error("chunk end did not produce a result or clear the chunk state");

  // A NUL inside a chunk stops the search for the rest of the chunk.
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !ends && text_byte == NUL_BYTE) |=> after_nul)
    else $error("NUL byte did not stop the search");

  // Below saturation each result carries the next line number.
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && ends && chunk_counter != '1) |=>
      (line_number == $past(chunk_counter) + 1'b1))
    else $error("line number did not advance by one");

  // A waiting result that is not taken holds off further input.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while the result register is full");

endmodule

[bench/tb_line_substring_matcher_unit.sv]
// Self-checking bench for line_substring_matcher_unit: streams text bytes under
// many pattern settings and compares every chunk result with its own line model.
// Depends on lsm_pkg and the line_substring_matcher_unit RTL.
module tb_line_substring_matcher_unit;
  import lsm_pkg::*;

  localparam int WIN          = PATTERN_BYTES_DEFAULT;
  localparam int CUT          = CHUNK_LIMIT_DEFAULT - 1;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN        = 4;
  localparam int TIMEOUT      = 10_000_000;

  typedef struct {
    logic                   matched;
    logic [LINE_W-1:0]      line;
    logic [CHUNK_LEN_W-1:0] len;
  } chunk_t;

  typedef struct {
    byte_t b;
    logic  fin;
  } text_item_t;

  // Line model: register copies, the search window and the chunks still owed.
  class chunk_ledger_t;
    logic [63:0]       pat_lo, pat_hi;
    logic [LEN_W-1:0]  pat_len;
    logic              fold_en;
    byte_t             window[WIN];
    int                chunk_bytes;
    bit                nul_seen, hit;
    logic [LINE_W-1:0] lines;
    chunk_t            due[$];
    int                errors, checked, hits;

    function new();
      pat_lo = '0; pat_hi = '0; pat_len = '0; fold_en = 1'b0;
      foreach (window[i]) window[i] = NUL_BYTE;
      chunk_bytes = 0; nul_seen = 0; hit = 0; lines = '0;
      errors = 0; checked = 0; hits = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_LOW:    pat_lo = value;
        REG_PATTERN_HIGH:   pat_hi = value;
        REG_PATTERN_LENGTH: pat_len = value[LEN_W-1:0];
        REG_FOLD_CASE:      fold_en = value[0];
        default: ;
      endcase
    endfunction

    function byte_t fold(byte_t b);
      if (fold_en && b >= UPPER_A && b <= UPPER_Z) return b + CASE_OFFSET;
      return b;
    endfunction

    function byte_t pat_byte(int i);
      if (i < 8) return pat_lo[8*i +: 8];
      if (i < 16) return pat_hi[8*(i-8) +: 8];
      return NUL_BYTE;
    endfunction

    // Pattern length in force: clipped to the window and cut at the first NUL.
    function int live_len();
      int n;
      n = (pat_len > WIN) ? WIN : int'(pat_len);
      for (int i = 0; i < n; i++) if (pat_byte(i) == NUL_BYTE) return i;
      return n;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Advances the model by one accepted byte and queues a chunk when one ends.
    function void take_byte(byte_t b, logic fin);
      int n;
      bit same;
      chunk_t c;
      n = live_len();
      chunk_bytes++;
      if (!nul_seen) begin
        if (b == NUL_BYTE) begin
          nul_seen = 1;
        end else begin
          for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
          window[0] = fold(b);
          if (n != 0 && chunk_bytes >= n) begin
            same = 1;
            for (int i = 0; i < n; i++)
              if (window[n-1-i] != fold(pat_byte(i))) same = 0;
            if (same) hit = 1;
          end
        end
      end
      if (b == NEWLINE_BYTE || chunk_bytes >= CUT || fin) begin
        if (lines != '1) lines++;
        c.matched = hit || (n == 0);
        c.line    = lines;
        c.len     = CHUNK_LEN_W'(chunk_bytes);
        due.push_back(c);
        chunk_bytes = 0;
        nul_seen    = 0;
        hit         = 0;
      end
    endfunction

    task flag_error(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_chunk(logic m, logic [LINE_W-1:0] ln, logic [CHUNK_LEN_W-1:0] cl);
      chunk_t c;
      if (due.size() == 0) begin
        flag_error($sformatf("result for line %0d with no chunk pending", ln));
        return;
      end
      c = due.pop_front();
      checked++;
      if (c.matched) hits++;
      if (m !== c.matched)
        flag_error($sformatf("line %0d: matched %b, expected %b", c.line, m, c.matched));
      if (ln !== c.line)
        flag_error($sformatf("line_number %0d, expected %0d", ln, c.line));
      if (cl !== c.len)
        flag_error($sformatf("line %0d: chunk_length %0d, expected %0d", c.line, cl, c.len));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  byte_t text_byte = NUL_BYTE;
  logic final_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic matched;
  logic [LINE_W-1:0] line_number;
  logic [CHUNK_LEN_W-1:0] chunk_length;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  chunk_ledger_t ledger = new();
  text_item_t  feed[$];
  byte_t       cur_pat[WIN];
  int          tx_left = 0, rx_left = 0;
  bit          tx_calm = 0, rx_calm = 0;
  int          bytes_sent = 0, random_sent = 0, settings = 0;

  line_substring_matcher_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .text_byte(text_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .matched(matched), .line_number(line_number), .chunk_length(chunk_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both channels are observed at the edge; results are checked before the
  // byte of the same edge is taken into the model.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) ledger.check_chunk(matched, line_number, chunk_length);
      if (in_valid && in_ready) ledger.take_byte(text_byte, final_byte);
    end
  end

  // Per-item random wait, with runs of back-to-back transfers now and then.
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(20, 60);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic byte_t swap_case(byte_t b);
    if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    if (b >= 8'h61 && b <= 8'h7A) return b - 8'h20;
    return b;
  endfunction

  // Letters of either case, with the characters that border the folding range.
  function automatic byte_t any_letter();
    byte_t b;
    case ($urandom_range(0, 11))
      0: b = 8'h40;
      1: b = 8'h5B;
      2: b = 8'h60;
      3: b = 8'h7B;
      4: b = 8'h20;
      default: begin
        b = 8'h61 + byte_t'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) b = b - 8'h20;
      end
    endcase
    return b;
  endfunction

  // Filler that often repeats pattern bytes, so near misses are common.
  function automatic byte_t near_byte(int plen);
    if (plen > 0 && $urandom_range(0, 1)) begin
      return $urandom_range(0, 2) == 0 ? swap_case(cur_pat[$urandom_range(0, plen - 1)])
                                       : cur_pat[$urandom_range(0, plen - 1)];
    end
    return any_letter();
  endfunction

  function automatic void push_byte(byte_t b, logic fin);
    text_item_t t;
    t.b   = b;
    t.fin = fin;
    feed.push_back(t);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(byte_t'(s[i]), 1'b0);
  endfunction

  function automatic void set_pattern(string s);
    foreach (cur_pat[i]) cur_pat[i] = (i < s.len()) ? byte_t'(s[i]) : NUL_BYTE;
  endfunction

  // Waits until every owed chunk has arrived, then lets the pipeline drain.
  // The first edge lets the monitor take in the last transfer of the feed.
  task automatic settle();
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_index_t idx, logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_reg(idx, value);
  endtask

  // Loads cur_pat with the given length and folding, once the block is idle.
  task automatic apply_config(logic [LEN_W-1:0] len, logic ic);
    logic [63:0] lo, hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = cur_pat[i];
      hi[8*i +: 8] = cur_pat[i+8];
    end
    settle();
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, 64'(len));
    write_reg(REG_FOLD_CASE, 64'(ic));
    settings++;
  endtask

  // Drives the queued bytes; valid stays high across back-to-back transfers.
  task automatic send_feed();
    int gap;
    foreach (feed[i]) begin
      gap = draw_wait(tx_left, tx_calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      text_byte  <= feed[i].b;
      final_byte <= feed[i].fin;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    bytes_sent += feed.size();
    feed.delete();
  endtask

  // Lines of filler with whole, partial or NUL-hidden copies of the pattern,
  // some noisy lines of raw bytes and some over-long lines.
  task automatic build_text(int target);
    int  plen, span, at, cut;
    bit  put, noisy;
    plen = ledger.live_len();
    while (feed.size() < target) begin
      noisy = ($urandom_range(0, 7) == 0);
      span  = ($urandom_range(0, 14) == 0) ? $urandom_range(90, 130) : $urandom_range(0, 24);
      put   = (plen > 0) && ($urandom_range(0, 2) != 0);
      at    = $urandom_range(0, span);
      for (int i = 0; i <= span; i++) begin
        if (put && i == at) begin
          if ($urandom_range(0, 5) == 0) push_byte(NUL_BYTE, 1'b0);
          cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plen - 1) : plen;
          for (int j = 0; j < cut; j++)
            push_byte($urandom_range(0, 1) ? swap_case(cur_pat[j]) : cur_pat[j], 1'b0);
        end
        if (i < span) push_byte(noisy ? byte_t'($urandom) : near_byte(plen), 1'b0);
      end
      case ($urandom_range(0, 9))
        0, 1: push_byte(near_byte(plen), 1'b1);
        9: begin
          // No terminator: the line runs on into the next one.
        end
        default: push_byte(NEWLINE_BYTE, 1'b0);
      endcase
    end
    feed[feed.size()-1].fin = 1'b1;
  endtask

  // One random setting followed by its text; the first few force the extremes.
  task automatic random_phase(int k);
    int r, len;
    logic ic;
    r   = $urandom_range(0, 9);
    len = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 16) :
          (r == 2) ? $urandom_range(17, 31) : $urandom_range(1, 6);
    ic  = 1'($urandom_range(0, 1));
    foreach (cur_pat[i])
      cur_pat[i] = ($urandom_range(0, 3) == 0) ? byte_t'($urandom_range(1, 255)) : any_letter();
    if ($urandom_range(0, 11) == 0) cur_pat[$urandom_range(0, 5)] = NUL_BYTE;
    if (k == 0) begin
      foreach (cur_pat[i]) cur_pat[i] = 8'hFF;
      len = WIN;
      ic  = 1'b1;
    end else if (k == 1) begin
      len = 31;
    end else if (k == 2) begin
      len = 0;
    end
    apply_config(LEN_W'(len), ic);
    build_text($urandom_range(80, 200));
    random_sent += feed.size();
    send_feed();
  endtask

  // Receiver: stalls a random number of cycles before taking each result.
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait(rx_left, rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings give an empty pattern, so every chunk matches.
    push_byte(8'hFF, 1'b0);
    push_byte(NUL_BYTE, 1'b0);
    push_byte(NEWLINE_BYTE, 1'b0);
    push_byte(8'h78, 1'b1);
    send_feed();

    // Case-sensitive two-byte pattern: exact hit, then a miss on case.
    set_pattern("aB");
    apply_config(LEN_W'(2), 1'b0);
    push_text("xaB\n");
    push_text("ab\n");
    send_feed();

    // Same pattern folded: a hit, then a NUL that hides the rest of the line.
    apply_config(LEN_W'(2), 1'b1);
    push_text("zAb\n");
    push_text("A");
    push_byte(NUL_BYTE, 1'b0);
    push_byte(8'h42, 1'b1);
    send_feed();

    // A NUL inside the pattern shortens it to the bytes before it.
    set_pattern("q");
    cur_pat[2] = 8'h72;
    cur_pat[3] = 8'h73;
    apply_config(LEN_W'(5), 1'b0);
    push_byte(8'h71, 1'b1);
    send_feed();

    for (int k = 0; random_sent < RANDOM_ITEMS; k++) random_phase(k);

    settle();
    repeat (2 * DRAIN) @(posedge clk);
    $display("Streamed %0d text bytes under %0d pattern settings.", bytes_sent, settings);
    $display("Compared %0d chunk results, %0d of them matches.", ledger.checked, ledger.hits);
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("Timed out with %0d chunk results outstanding.", ledger.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
